@@ src/jess_pkg.sv @@
`timescale 1ns / 1ps
package jess_pkg;

    localparam int COUNT_BITS = 24;
    localparam int LIMIT_W    = 24;
    localparam int CMP_W      = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;
    localparam int SHORT_FILE = 10;
    localparam int TIFF_MIN   = 14;
    localparam int HDR_BYTES  = 8;
    localparam int SIG_BYTES  = 6;
    localparam int APP1_MIN   = 8;

    localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = LIMIT_W'(128 * 1024);

    localparam logic [7:0] MK_FILL  = 8'hFF;
    localparam logic [7:0] MK_SOI   = 8'hD8;
    localparam logic [7:0] MK_EOI   = 8'hD9;
    localparam logic [7:0] MK_SOS   = 8'hDA;
    localparam logic [7:0] MK_RST0  = 8'hD0;
    localparam logic [7:0] MK_RST7  = 8'hD7;
    localparam logic [7:0] MK_TEM   = 8'h01;
    localparam logic [7:0] MK_APP1  = 8'hE1;
    localparam logic [7:0] MK_STUFF = 8'h00;
    localparam logic [7:0] SIG_EVEN = 8'h45;
    localparam logic [7:0] SIG_ODD  = 8'h78;
    localparam logic [7:0] BO_II    = 8'h49;
    localparam logic [7:0] BO_MM    = 8'h4D;
    localparam logic [15:0] TIFF_MAGIC = 16'd42;

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MARK0,
        PH_MARK1,
        PH_LEN0,
        PH_LEN1,
        PH_SKIP,
        PH_SIG,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OC_EXIF,
        OC_NOT_JPEG,
        OC_NO_EXIF,
        OC_BAD_TIFF
    } t_outcome;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic        verdict_valid;
        logic [1:0]  outcome;
        logic        little_endian;
        logic [15:0] first_ifd_offset;
        logic [15:0] tiff_length;
    } t_out_item;

    typedef struct packed {
        t_outcome    outcome;
        logic        little_endian;
        logic [15:0] ifd;
        logic [15:0] tlen;
    } t_decision;

endpackage

@@ src/jpeg_exif_segment_scanner_core.sv @@
`timescale 1ns / 1ps
// Byte-stream JPEG Exif scanner: takes one file byte per cycle and returns one result per
// byte, at a sustained rate of one byte per clock unless the output side stalls. Each byte
// passes an input register, one update of the marker-walk state, and an output register,
// so the block accepts a new byte every cycle unless the output side stalls. Results carry
// the TIFF payload bytes of the Exif APP1 segment with their offsets, and exactly one
// verdict per file (outcome, byte order, IFD0 offset, TIFF length). Write scan_limit only
// while no transaction is in flight.
module jpeg_exif_segment_scanner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jess_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  jess_pkg::t_in_item            i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output jess_pkg::t_out_item           o_data
);
    import jess_pkg::*;

    logic [LIMIT_W-1:0] r_scan_limit;
    logic               r_in_valid;
    t_in_item           r_in_item;
    logic               r_out_valid;
    t_out_item          r_out_item;
    logic               advance;
    t_out_item          step_result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= SCAN_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_scan_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item <= i_data;
        end
    end

    jess_scan_fsm u_scan_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_in_item),
        .i_scan_limit (r_scan_limit),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_item;

`ifndef ASSERT_OFF
    a_exif_ifd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.verdict_valid && o_data.outcome == OC_EXIF)
        |-> (o_data.first_ifd_offset >= 16'(HDR_BYTES)
             && o_data.first_ifd_offset < o_data.tiff_length))
        else $error("exif verdict with IFD0 offset out of range");

    a_verdict_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.verdict_valid)
        |-> (o_data.outcome == 2'd0 && o_data.tiff_length == 16'h0
             && o_data.first_ifd_offset == 16'h0 && !o_data.little_endian))
        else $error("verdict fields set without a verdict");

    a_payload_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.payload_valid)
        |-> (o_data.payload_byte == 8'h0 && o_data.payload_offset == 16'h0))
        else $error("payload fields set without a payload byte");

    a_order_only_exif: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.verdict_valid && o_data.outcome != OC_EXIF)
        |-> (!o_data.little_endian && o_data.first_ifd_offset == 16'h0))
        else $error("byte order or IFD0 offset reported without exif");
`endif

endmodule

@@ src/jess_tiff_check.sv @@
`timescale 1ns / 1ps
module jess_tiff_check (
    input  logic [63:0]          i_hdr,
    input  logic [15:0]          i_tlen,
    output jess_pkg::t_decision  o_dec
);
    import jess_pkg::*;

    logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
    logic        is_ii;
    logic        is_mm;
    logic [15:0] magic;
    logic [31:0] ifd;
    logic        hdr_ok;

    assign {b0, b1, b2, b3, b4, b5, b6, b7} = i_hdr;
    assign is_ii = (b0 == BO_II) && (b1 == BO_II);
    assign is_mm = (b0 == BO_MM) && (b1 == BO_MM);
    assign magic = is_ii ? {b3, b2} : {b2, b3};
    assign ifd   = is_ii ? {b7, b6, b5, b4} : {b4, b5, b6, b7};

    assign hdr_ok = (i_tlen >= 16'(TIFF_MIN)) && (is_ii || is_mm) && (magic == TIFF_MAGIC)
                    && (ifd >= 32'(HDR_BYTES)) && (ifd < {16'h0, i_tlen});

    always_comb begin
        o_dec.tlen = i_tlen;
        if (hdr_ok) begin
            o_dec.outcome       = OC_EXIF;
            o_dec.little_endian = is_ii;
            o_dec.ifd           = ifd[15:0];
        end else begin
            o_dec.outcome       = OC_BAD_TIFF;
            o_dec.little_endian = 1'b0;
            o_dec.ifd           = 16'h0;
        end
    end

endmodule

@@ src/jess_scan_fsm.sv @@
`timescale 1ns / 1ps
module jess_scan_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  jess_pkg::t_in_item            i_item,
    input  logic [jess_pkg::LIMIT_W-1:0]  i_scan_limit,
    output jess_pkg::t_out_item           o_result
);
    import jess_pkg::*;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_bytes_seen, n_bytes_seen;
    logic [15:0]           r_seg_left, n_seg_left;
    logic [15:0]           r_seg_len, n_seg_len;
    logic                  r_in_app1, n_in_app1;
    logic [2:0]            r_sig_idx, n_sig_idx;
    logic [15:0]           r_pay_cnt, n_pay_cnt;
    logic [63:0]           r_hdr, n_hdr;
    logic                  r_verdict_done, n_verdict_done;
    logic                  r_held, n_held;
    t_decision             r_held_dec, n_held_dec;

    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] lim_ext;
    logic             in_range;
    logic             at_limit;
    logic             past_short;
    logic [63:0]      hdr_shift;
    logic [63:0]      tiff_hdr;
    t_decision        tiff_dec;
    t_decision        no_exif_dec;
    t_decision        not_jpeg_dec;
    logic [7:0]       b;
    logic [7:0]       sig_byte;
    logic [15:0]      left_dec;
    t_out_item        res;

    assign b          = i_item.data_byte;
    assign idx_ext    = CMP_W'(r_bytes_seen);
    assign lim_ext    = CMP_W'(i_scan_limit);
    assign in_range   = idx_ext < lim_ext;
    assign at_limit   = (idx_ext + CMP_W'(1)) >= lim_ext;
    assign past_short = idx_ext >= CMP_W'(SHORT_FILE - 1);
    assign hdr_shift  = {r_hdr[55:0], b};
    assign tiff_hdr   = (r_pay_cnt < 16'(HDR_BYTES)) ? hdr_shift : r_hdr;
    assign sig_byte   = r_sig_idx[0] ? SIG_ODD : SIG_EVEN;
    assign left_dec   = r_seg_left - 16'd1;

    assign no_exif_dec  = '{outcome: OC_NO_EXIF, little_endian: 1'b0, ifd: 16'h0, tlen: 16'h0};
    assign not_jpeg_dec = '{outcome: OC_NOT_JPEG, little_endian: 1'b0, ifd: 16'h0, tlen: 16'h0};

    jess_tiff_check u_tiff_check (
        .i_hdr  (tiff_hdr),
        .i_tlen (r_seg_len - 16'(APP1_MIN)),
        .o_dec  (tiff_dec)
    );

    always_comb begin
        n_phase        = r_phase;
        n_bytes_seen   = r_bytes_seen;
        n_seg_left     = r_seg_left;
        n_seg_len      = r_seg_len;
        n_in_app1      = r_in_app1;
        n_sig_idx      = r_sig_idx;
        n_pay_cnt      = r_pay_cnt;
        n_hdr          = r_hdr;
        n_verdict_done = r_verdict_done;
        n_held         = r_held;
        n_held_dec     = r_held_dec;
        res            = '0;

        if (in_range) begin
            unique case (r_phase)
                PH_SOI0: begin
                    if (b == MK_FILL) begin
                        n_phase = PH_SOI1;
                    end else begin
                        n_held = 1'b1; n_held_dec = not_jpeg_dec; n_phase = PH_DONE;
                    end
                end
                PH_SOI1: begin
                    if (b == MK_SOI) begin
                        n_phase = PH_MARK0;
                    end else begin
                        n_held = 1'b1; n_held_dec = not_jpeg_dec; n_phase = PH_DONE;
                    end
                end
                PH_MARK0: begin
                    if (b == MK_FILL) begin
                        n_phase = PH_MARK1;
                    end else begin
                        n_held = 1'b1; n_held_dec = no_exif_dec; n_phase = PH_DONE;
                    end
                end
                PH_MARK1: begin
                    priority if (b == MK_FILL) begin
                        n_phase = PH_MARK1;
                    end else if (b == MK_STUFF || b == MK_SOI || b == MK_EOI
                                 || b == MK_SOS) begin
                        n_held = 1'b1; n_held_dec = no_exif_dec; n_phase = PH_DONE;
                    end else if ((b >= MK_RST0 && b <= MK_RST7) || b == MK_TEM) begin
                        n_phase = PH_MARK0;
                    end else begin
                        n_in_app1 = (b == MK_APP1);
                        n_phase   = PH_LEN0;
                    end
                end
                PH_LEN0: begin
                    n_seg_len = {b, 8'h00};
                    n_phase   = PH_LEN1;
                end
                PH_LEN1: begin
                    n_seg_len = {r_seg_len[15:8], b};
                    if (n_seg_len < 16'd2) begin
                        n_held = 1'b1; n_held_dec = no_exif_dec; n_phase = PH_DONE;
                    end else begin
                        n_seg_left = n_seg_len - 16'd2;
                        n_sig_idx  = 3'd0;
                        priority if (n_seg_left == 16'h0) begin
                            n_phase = PH_MARK0;
                        end else if (r_in_app1 && n_seg_len >= 16'(APP1_MIN)) begin
                            n_phase = PH_SIG;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_seg_left = left_dec;
                    if (left_dec == 16'h0) begin
                        n_phase = PH_MARK0;
                    end
                end
                PH_SIG: begin
                    n_seg_left = left_dec;
                    if (b != sig_byte) begin
                        n_phase = (left_dec == 16'h0) ? PH_MARK0 : PH_SKIP;
                    end else begin
                        n_sig_idx = r_sig_idx + 3'd1;
                        if (n_sig_idx >= 3'(SIG_BYTES)) begin
                            n_pay_cnt = 16'h0;
                            n_hdr     = 64'h0;
                            if (left_dec == 16'h0) begin
                                n_held = 1'b1; n_held_dec = tiff_dec; n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res.payload_valid  = 1'b1;
                    res.payload_byte   = b;
                    res.payload_offset = r_pay_cnt;
                    n_hdr      = tiff_hdr;
                    n_pay_cnt  = r_pay_cnt + 16'd1;
                    n_seg_left = left_dec;
                    if (left_dec == 16'h0) begin
                        n_held = 1'b1; n_held_dec = tiff_dec; n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (n_held && !r_verdict_done && past_short) begin
                res.verdict_valid    = 1'b1;
                res.outcome          = n_held_dec.outcome;
                res.little_endian    = n_held_dec.little_endian;
                res.first_ifd_offset = n_held_dec.ifd;
                res.tiff_length      = n_held_dec.tlen;
                n_verdict_done       = 1'b1;
            end
        end

        if (!n_verdict_done && (i_item.last_byte || at_limit)) begin
            res.verdict_valid    = 1'b1;
            res.outcome          = OC_NO_EXIF;
            res.little_endian    = 1'b0;
            res.first_ifd_offset = 16'h0;
            res.tiff_length      = 16'h0;
            n_verdict_done       = 1'b1;
        end

        if (r_bytes_seen != '1) begin
            n_bytes_seen = r_bytes_seen + COUNT_BITS'(1);
        end

        if (i_item.last_byte) begin
            n_phase        = PH_SOI0;
            n_bytes_seen   = '0;
            n_seg_left     = 16'h0;
            n_seg_len      = 16'h0;
            n_in_app1      = 1'b0;
            n_sig_idx      = 3'd0;
            n_pay_cnt      = 16'h0;
            n_hdr          = 64'h0;
            n_verdict_done = 1'b0;
            n_held         = 1'b0;
            n_held_dec     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SOI0;
            r_bytes_seen   <= '0;
            r_seg_left     <= 16'h0;
            r_seg_len      <= 16'h0;
            r_in_app1      <= 1'b0;
            r_sig_idx      <= 3'd0;
            r_pay_cnt      <= 16'h0;
            r_hdr          <= 64'h0;
            r_verdict_done <= 1'b0;
            r_held         <= 1'b0;
            r_held_dec     <= '0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_bytes_seen   <= n_bytes_seen;
            r_seg_left     <= n_seg_left;
            r_seg_len      <= n_seg_len;
            r_in_app1      <= n_in_app1;
            r_sig_idx      <= n_sig_idx;
            r_pay_cnt      <= n_pay_cnt;
            r_hdr          <= n_hdr;
            r_verdict_done <= n_verdict_done;
            r_held         <= n_held;
            r_held_dec     <= n_held_dec;
        end
    end

    assign o_result = res;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import jess_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int MAX_REPORTS     = 10;
    localparam logic [7:0] PLAIN_MARKERS [6] = '{8'hE0, 8'hE2, 8'hDB, 8'hC0, 8'hC4, 8'hFE};

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    t_in_item           in_item = '0;
    logic               out_ready = 1'b0;
    logic               dut_in_ready;
    logic               dut_out_valid;
    t_out_item          dut_out;

    always #6 i_clk = ~i_clk;

    jpeg_exif_segment_scanner_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_valid    (in_valid),
        .o_ready    (dut_in_ready),
        .i_data     (in_item),
        .o_valid    (dut_out_valid),
        .i_ready    (out_ready),
        .o_data     (dut_out)
    );

    // scanner state mirror
    logic [LIMIT_W-1:0]    limit_q = SCAN_LIMIT_RST;
    t_phase                walk_phase;
    logic [COUNT_BITS-1:0] byte_pos;
    logic [15:0]           seg_left;
    logic [15:0]           seg_len;
    logic                  app1_seg;
    logic [2:0]            sig_pos;
    logic [15:0]           tiff_pos;
    logic [63:0]           tiff_head;
    logic                  verdict_sent;
    logic                  decision_held;
    t_decision             held_dec;

    t_in_item   byte_queue[$];
    t_out_item  expected_results[$];
    logic [7:0] file_bytes[$];
    int         queued_items = 0;
    int         mismatches = 0;
    int         result_count = 0;
    int         idle_cycles = 0;
    int         send_gap = 0;
    int         stall_left = 0;
    bit         steady = 1'b0;
    bit         byte_taken = 1'b0;

    task automatic restart_file();
        walk_phase    = PH_SOI0;
        byte_pos      = '0;
        seg_left      = '0;
        seg_len       = '0;
        app1_seg      = 1'b0;
        sig_pos       = '0;
        tiff_pos      = '0;
        tiff_head     = '0;
        verdict_sent  = 1'b0;
        decision_held = 1'b0;
        held_dec      = '0;
    endtask

    task automatic take_decision(t_outcome oc, logic le, logic [15:0] ifd, logic [15:0] tl);
        decision_held = 1'b1;
        held_dec      = t_decision'{oc, le, ifd, tl};
        walk_phase    = PH_DONE;
    endtask

    task automatic judge_tiff();
        logic [15:0] tl;
        logic [15:0] magic;
        logic [31:0] ifd;
        logic        le;
        tl = seg_len - 16'd8;
        if (tl < TIFF_MIN) begin
            take_decision(OC_BAD_TIFF, 1'b0, 16'd0, tl);
        end else if (tiff_head[63:48] != {BO_II, BO_II} && tiff_head[63:48] != {BO_MM, BO_MM}) begin
            take_decision(OC_BAD_TIFF, 1'b0, 16'd0, tl);
        end else begin
            le = (tiff_head[63:56] == BO_II);
            if (le) begin
                magic = {tiff_head[39:32], tiff_head[47:40]};
                ifd   = {tiff_head[7:0], tiff_head[15:8], tiff_head[23:16], tiff_head[31:24]};
            end else begin
                magic = tiff_head[47:32];
                ifd   = tiff_head[31:0];
            end
            if (magic != TIFF_MAGIC || ifd < 32'd8 || ifd >= {16'd0, tl})
                take_decision(OC_BAD_TIFF, 1'b0, 16'd0, tl);
            else
                take_decision(OC_EXIF, le, ifd[15:0], tl);
        end
    endtask

    task automatic walk_byte(input logic [7:0] b, inout t_out_item r);
        case (walk_phase)
            PH_SOI0: begin
                if (b == MK_FILL) walk_phase = PH_SOI1;
                else take_decision(OC_NOT_JPEG, 1'b0, 16'd0, 16'd0);
            end
            PH_SOI1: begin
                if (b == MK_SOI) walk_phase = PH_MARK0;
                else take_decision(OC_NOT_JPEG, 1'b0, 16'd0, 16'd0);
            end
            PH_MARK0: begin
                if (b == MK_FILL) walk_phase = PH_MARK1;
                else take_decision(OC_NO_EXIF, 1'b0, 16'd0, 16'd0);
            end
            PH_MARK1: begin
                if (b == MK_FILL) begin
                end else if (b == MK_STUFF || b == MK_SOI || b == MK_EOI || b == MK_SOS) begin
                    take_decision(OC_NO_EXIF, 1'b0, 16'd0, 16'd0);
                end else if ((b >= MK_RST0 && b <= MK_RST7) || b == MK_TEM) begin
                    walk_phase = PH_MARK0;
                end else begin
                    app1_seg   = (b == MK_APP1);
                    walk_phase = PH_LEN0;
                end
            end
            PH_LEN0: begin
                seg_len    = {b, 8'h00};
                walk_phase = PH_LEN1;
            end
            PH_LEN1: begin
                seg_len = {seg_len[15:8], b};
                if (seg_len < 16'd2) begin
                    take_decision(OC_NO_EXIF, 1'b0, 16'd0, 16'd0);
                end else begin
                    seg_left = seg_len - 16'd2;
                    sig_pos  = '0;
                    if (seg_left == 16'd0) walk_phase = PH_MARK0;
                    else if (app1_seg && seg_len >= APP1_MIN) walk_phase = PH_SIG;
                    else walk_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                seg_left = seg_left - 16'd1;
                if (seg_left == 16'd0) walk_phase = PH_MARK0;
            end
            PH_SIG: begin
                seg_left = seg_left - 16'd1;
                if (b != (sig_pos[0] ? SIG_ODD : SIG_EVEN)) begin
                    walk_phase = PH_SKIP;
                    if (seg_left == 16'd0) walk_phase = PH_MARK0;
                end else begin
                    sig_pos = sig_pos + 3'd1;
                    if (sig_pos >= SIG_BYTES) begin
                        tiff_pos  = '0;
                        tiff_head = '0;
                        if (seg_left == 16'd0) judge_tiff();
                        else walk_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.payload_valid  = 1'b1;
                r.payload_byte   = b;
                r.payload_offset = tiff_pos;
                if (tiff_pos < HDR_BYTES) tiff_head = {tiff_head[55:0], b};
                tiff_pos = tiff_pos + 16'd1;
                seg_left = seg_left - 16'd1;
                if (seg_left == 16'd0) judge_tiff();
            end
            default: begin
            end
        endcase
    endtask

    task automatic give_verdict(inout t_out_item r, input t_decision d);
        r.verdict_valid    = 1'b1;
        r.outcome          = d.outcome;
        r.little_endian    = d.little_endian;
        r.first_ifd_offset = d.ifd;
        r.tiff_length      = d.tlen;
        verdict_sent       = 1'b1;
    endtask

    task automatic predict_byte(input t_in_item it, output t_out_item r);
        logic [COUNT_BITS:0] next_pos;
        r = '0;
        next_pos = {1'b0, byte_pos} + 1'b1;
        if (byte_pos < limit_q) begin
            walk_byte(it.data_byte, r);
            if (decision_held && !verdict_sent && next_pos >= SHORT_FILE)
                give_verdict(r, held_dec);
        end
        if (!verdict_sent && (it.last_byte || next_pos >= {1'b0, limit_q}))
            give_verdict(r, t_decision'{OC_NO_EXIF, 1'b0, 16'd0, 16'd0});
        if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
        if (it.last_byte) restart_file();
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic commit_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++) begin
            byte_queue.push_back(t_in_item'{file_bytes[i], i == file_bytes.size() - 1});
            queued_items++;
        end
    endtask

    task automatic add_other_segment();
        int          len;
        int          i;
        logic [7:0]  mk;
        logic [15:0] len16;
        file_bytes.push_back(MK_FILL);
        if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(0, 2)) file_bytes.push_back(MK_FILL);
            if ($urandom_range(0, 8) == 8) file_bytes.push_back(MK_TEM);
            else file_bytes.push_back(MK_RST0 + 8'($urandom_range(0, 7)));
        end else begin
            case ($urandom_range(0, 9))
                0:       mk = 8'($urandom);
                1, 2:    mk = MK_APP1;
                default: mk = PLAIN_MARKERS[$urandom_range(0, 5)];
            endcase
            len   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 14);
            len16 = 16'(len);
            file_bytes.push_back(mk);
            file_bytes.push_back(len16[15:8]);
            file_bytes.push_back(len16[7:0]);
            for (i = 2; i < len; i++) file_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic add_exif_segment(int tlen, bit sane);
        logic [7:0]  head [8];
        logic [15:0] seg;
        logic [15:0] magic;
        logic [31:0] ifd;
        int          pick;
        int          order;
        int          i;
        seg = 16'(tlen + 8);
        file_bytes.push_back(MK_FILL);
        file_bytes.push_back(MK_APP1);
        file_bytes.push_back(seg[15:8]);
        file_bytes.push_back(seg[7:0]);
        pick = sane ? 0 : $urandom_range(0, 19);
        if (pick == 17 || pick == 18) begin
            file_bytes.push_back(8'h45);
            file_bytes.push_back(8'h78);
            file_bytes.push_back(8'h69);
            file_bytes.push_back(8'h66);
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'h00);
        end else begin
            for (i = 0; i < SIG_BYTES; i++) file_bytes.push_back(i[0] ? SIG_ODD : SIG_EVEN);
            if (pick == 19)
                file_bytes[file_bytes.size() - 1 - $urandom_range(0, 5)] = 8'($urandom);
        end
        magic = (sane || $urandom_range(0, 9) != 0) ? TIFF_MAGIC : 16'($urandom);
        if (tlen > 8 && (sane || $urandom_range(0, 99) < 85))
            ifd = 32'($urandom_range(8, tlen - 1));
        else if ($urandom_range(0, 1) == 0)
            ifd = 32'($urandom_range(0, 15));
        else
            ifd = $urandom;
        order = sane ? $urandom_range(0, 89) : $urandom_range(0, 99);
        if (order < 45) begin
            head = '{BO_II, BO_II, magic[7:0], magic[15:8],
                     ifd[7:0], ifd[15:8], ifd[23:16], ifd[31:24]};
        end else if (order < 90) begin
            head = '{BO_MM, BO_MM, magic[15:8], magic[7:0],
                     ifd[31:24], ifd[23:16], ifd[15:8], ifd[7:0]};
        end else begin
            head = '{8'($urandom), 8'($urandom), magic[15:8], magic[7:0],
                     ifd[31:24], ifd[23:16], ifd[15:8], ifd[7:0]};
        end
        for (i = 0; i < tlen; i++) file_bytes.push_back(i < 8 ? head[i] : 8'($urandom));
    endtask

    task automatic build_file();
        int kind;
        int r;
        int cut;
        file_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 88) begin
            file_bytes.push_back(MK_FILL);
            file_bytes.push_back(MK_SOI);
            repeat ($urandom_range(0, 3)) add_other_segment();
            if ($urandom_range(0, 9) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 60) add_exif_segment($urandom_range(14, 40), 1'b0);
                else if (r < 75) add_exif_segment($urandom_range(8, 13), 1'b0);
                else if (r < 85) add_exif_segment($urandom_range(0, 7), 1'b0);
                else add_exif_segment($urandom_range(41, 120), 1'b0);
            end
            repeat ($urandom_range(0, 2)) add_other_segment();
            case ($urandom_range(0, 3))
                1: begin
                    file_bytes.push_back(MK_FILL);
                    file_bytes.push_back(MK_EOI);
                end
                2: begin
                    file_bytes.push_back(MK_FILL);
                    file_bytes.push_back(MK_SOS);
                    repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
                end
                3: repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
                default: begin
                end
            endcase
            if (kind >= 70 && kind < 78)
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            if (kind >= 78) begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
        end else begin
            if ($urandom_range(0, 1) == 0) begin
                file_bytes.push_back(MK_FILL);
                file_bytes.push_back(MK_SOI);
            end
            repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
        end
        commit_file();
    endtask

    task automatic fill_random(int n);
        int start;
        start = queued_items;
        while (queued_items - start < n) build_file();
    endtask

    task automatic queue_directed();
        file_bytes = '{MK_FILL};
        commit_file();
        file_bytes = '{8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        commit_file();
        file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_RST0, MK_FILL, MK_TEM,
                       MK_FILL, MK_SOS, 8'h00, 8'h00};
        commit_file();
        file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_APP1, 8'h00, 8'h01};
        commit_file();
    endtask

    task automatic queue_longest_tiff();
        file_bytes = '{MK_FILL, MK_SOI};
        add_exif_segment(160, 1'b1);
        file_bytes.push_back(MK_FILL);
        file_bytes.push_back(MK_EOI);
        commit_file();
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        limit_q   = v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // drive
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (!in_valid || byte_taken) begin
                byte_taken = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    in_item  <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                    send_gap  = steady ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!steady && $urandom_range(0, 4) == 0) stall_left = pick_gap();
            end
            if ($urandom_range(0, 299) == 0) steady = !steady;
        end
    end

    // sample, predict, compare
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (rst_n) begin
            idle_cycles++;
            if (in_valid && dut_in_ready) begin
                predict_byte(in_item, want);
                expected_results.push_back(want);
                byte_taken  = 1'b1;
                idle_cycles = 0;
            end
            if (dut_out_valid && out_ready) begin
                idle_cycles = 0;
                got = dut_out;
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected transaction %0d: %h", result_count, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.payload_valid !== want.payload_valid
                        || got.payload_byte !== want.payload_byte
                        || got.payload_offset !== want.payload_offset
                        || got.verdict_valid !== want.verdict_valid
                        || got.outcome !== want.outcome
                        || got.little_endian !== want.little_endian
                        || got.first_ifd_offset !== want.first_ifd_offset
                        || got.tiff_length !== want.tiff_length) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch on transaction %0d", result_count);
                            $display("  expected pv=%0b pb=%h po=%0d vv=%0b oc=%0d le=%0b ifd=%0d tl=%0d",
                                     want.payload_valid, want.payload_byte, want.payload_offset,
                                     want.verdict_valid, want.outcome, want.little_endian,
                                     want.first_ifd_offset, want.tiff_length);
                            $display("  actual   pv=%0b pb=%h po=%0d vv=%0b oc=%0d le=%0b ifd=%0d tl=%0d",
                                     got.payload_valid, got.payload_byte, got.payload_offset,
                                     got.verdict_valid, got.outcome, got.little_endian,
                                     got.first_ifd_offset, got.tiff_length);
                        end
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        restart_file();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        queue_directed();
        fill_random(200);
        settle();

        write_limit(LIMIT_W'(10));
        fill_random(150);
        settle();

        write_limit(LIMIT_W'($urandom_range(11, 60)));
        fill_random(150);
        settle();

        write_limit('1);
        queue_longest_tiff();
        fill_random(80);
        settle();

        write_limit(SCAN_LIMIT_RST);
        fill_random(60);
        settle();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
